// ----- src/lspd_pkg.sv -----
// ----------------------------------------------------------------------------
// lspd_pkg
// Shared types and constants of the slot pool with recency list and demote.
// ----------------------------------------------------------------------------
package lspd_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = SLOT_W + 1;
    localparam int TILE_W  = 18;
    localparam int CMD_W   = 3;
    localparam int CAP_W   = 7;

    // free-slot search works on groups of eight in-use bits
    localparam int GRP_W   = 3;
    localparam int GRP     = 1 << GRP_W;
    localparam int NGRP    = SLOTS / GRP;
    localparam int NGRP_W  = SLOT_W - GRP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(SLOTS);

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TOUCH   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEMOTE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DETACH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UPDATE,
        ST_LINK,
        ST_RESPOND
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic update;
        logic link;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic need_update;
        logic need_link;
    } t_dp_flags;

endpackage

// ----- src/lspd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lspd_ctrl
// Command sequencer: decode, update/unlink, link, respond.
// ----------------------------------------------------------------------------
module lspd_ctrl
    import lspd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_dp_flags i_flags,
    output t_dp_ctl   o_ctl,
    output logic      busy,
    output logic      o_result_valid
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = i_flags.need_update ? ST_UPDATE : ST_RESPOND;
            end
            ST_UPDATE: begin
                n_state = i_flags.need_link ? ST_LINK : ST_RESPOND;
            end
            ST_LINK: begin
                n_state = ST_RESPOND;
            end
            ST_RESPOND: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl          = '0;
        busy           = 1'b1;
        o_result_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_ctl.load = start;
            end
            ST_DECODE:  o_ctl.decode   = 1'b1;
            ST_UPDATE:  o_ctl.update   = 1'b1;
            ST_LINK:    o_ctl.link     = 1'b1;
            ST_RESPOND: o_result_valid = 1'b1;
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/lspd_datapath.sv -----
// ----------------------------------------------------------------------------
// lspd_datapath
// Slot flags, recency list memories, owner memory and result registers.
// ----------------------------------------------------------------------------
module lspd_datapath
    import lspd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_ctl            i_ctl,
    output t_dp_flags          o_flags,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [TILE_W-1:0]  i_tile,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_data,
    output logic               o_status,
    output logic [SLOT_W-1:0]  o_granted_slot,
    output logic               o_evicted_valid,
    output logic [TILE_W-1:0]  o_evicted_tile,
    output logic [COUNT_W-1:0] o_used_slots
);

    typedef struct packed {
        logic free;
        logic evict;
        logic unlink;
        logic link_new;
        logic link_old;
        logic empty;
        logic release_slot;
        logic detach;
    } t_plan;

    // latched command
    logic [CMD_W-1:0]   r_cmd;
    logic [TILE_W-1:0]  r_tile;
    logic [SLOT_W-1:0]  r_sidx;
    logic [SLOT_W-1:0]  r_slot;
    t_plan              r_plan;

    // pool state
    logic [CAP_W-1:0]   r_cap,       n_cap;
    logic [SLOT_W-1:0]  r_head,      n_head;
    logic [SLOT_W-1:0]  r_tail,      n_tail;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic [SLOTS-1:0]   r_in_use,    n_in_use;
    logic [SLOTS-1:0]   r_has_owner, n_has_owner;

    // list and owner memories
    logic [SLOT_W-1:0]  r_older_mem [SLOTS];
    logic [SLOT_W-1:0]  r_newer_mem [SLOTS];
    logic [TILE_W-1:0]  r_owner_mem [SLOTS];
    logic [SLOT_W-1:0]  r_rd_older;
    logic [SLOT_W-1:0]  r_rd_newer;
    logic [TILE_W-1:0]  r_rd_owner;

    logic               older_we, newer_we, owner_we;
    logic [SLOT_W-1:0]  older_waddr, older_wdata;
    logic [SLOT_W-1:0]  newer_waddr, newer_wdata;

    // free-slot search, first level registered
    logic [NGRP-1:0]    r_grp_free, n_grp_free;
    logic [GRP_W-1:0]   r_grp_idx [NGRP];
    logic [GRP_W-1:0]   n_grp_idx [NGRP];

    // results
    logic               r_status;
    logic [SLOT_W-1:0]  r_granted;
    logic               r_ev_valid,  n_ev_valid;
    logic [TILE_W-1:0]  r_ev_tile,   n_ev_tile;

    // decode signals
    logic [COUNT_W-1:0] cap_eff;
    logic               room;
    logic [SLOT_W-1:0]  free_idx;
    logic [SLOT_W-1:0]  target;
    logic               is_alloc;
    logic               slot_cmd;
    logic               hit;
    t_plan              plan;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_free[g] = ~(&r_in_use[g*GRP +: GRP]);
            n_grp_idx[g]  = '0;
            for (int i = GRP - 1; i >= 0; i--) begin
                if (!r_in_use[g*GRP + i]) begin
                    n_grp_idx[g] = GRP_W'(i);
                end
            end
        end
    end

    always_comb begin
        free_idx = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                free_idx = {NGRP_W'(g), r_grp_idx[g]};
            end
        end
    end

    // capacity of zero acts as one, above the pool size as the pool size
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = COUNT_W'(1);
        end else if (COUNT_W'(r_cap) > COUNT_W'(SLOTS)) begin
            cap_eff = COUNT_W'(SLOTS);
        end else begin
            cap_eff = COUNT_W'(r_cap);
        end
    end

    always_comb begin
        is_alloc = (r_cmd == CMD_ALLOC);
        room     = (r_count < cap_eff);
        slot_cmd = (r_cmd == CMD_TOUCH) || (r_cmd == CMD_DEMOTE)
                || (r_cmd == CMD_DETACH) || (r_cmd == CMD_RELEASE);
        hit      = r_in_use[r_sidx];
        if (is_alloc) begin
            target = room ? free_idx : r_tail;
        end else begin
            target = r_sidx;
        end

        plan              = '0;
        plan.free         = is_alloc && room;
        plan.evict        = is_alloc && !room;
        plan.empty        = (r_count == '0);
        plan.release_slot = (r_cmd == CMD_RELEASE) && hit;
        plan.detach       = (r_cmd == CMD_DETACH) && hit;
        plan.link_new     = plan.free
                         || (plan.evict && target != r_head)
                         || ((r_cmd == CMD_TOUCH) && hit && target != r_head);
        plan.link_old     = (r_cmd == CMD_DEMOTE) && hit && target != r_tail;
        plan.unlink       = (plan.link_new && !plan.free) || plan.link_old
                         || (plan.release_slot && r_count > COUNT_W'(1));
    end

    assign o_flags.need_update = is_alloc || (slot_cmd && hit);
    assign o_flags.need_link   = r_plan.link_new || r_plan.link_old;

    always_comb begin
        n_cap       = r_cap;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_in_use    = r_in_use;
        n_has_owner = r_has_owner;
        n_ev_valid  = r_ev_valid;
        n_ev_tile   = r_ev_tile;
        older_we    = 1'b0;
        older_waddr = r_rd_newer;
        older_wdata = r_rd_older;
        newer_we    = 1'b0;
        newer_waddr = r_rd_older;
        newer_wdata = r_rd_newer;
        owner_we    = 1'b0;

        if (i_cfg_we) begin
            n_cap = i_cfg_data;
        end

        if (i_ctl.decode) begin
            n_ev_valid = 1'b0;
            n_ev_tile  = '0;
            if (r_cmd == CMD_CLEAR) begin
                n_in_use    = '0;
                n_has_owner = '0;
                n_count     = '0;
            end
        end

        if (i_ctl.update) begin
            // take the slot out of the list
            if (r_plan.unlink) begin
                if (r_slot == r_head) begin
                    n_head = r_rd_older;
                end else begin
                    older_we = 1'b1;
                end
                if (r_slot == r_tail) begin
                    n_tail = r_rd_newer;
                end else begin
                    newer_we = 1'b1;
                end
            end
            if (r_plan.free || r_plan.evict) begin
                owner_we              = 1'b1;
                n_has_owner[r_slot]   = 1'b1;
                if (r_plan.evict && r_has_owner[r_slot]) begin
                    n_ev_valid = 1'b1;
                    n_ev_tile  = r_rd_owner;
                end
            end
            if (r_plan.free) begin
                n_in_use[r_slot] = 1'b1;
                n_count          = r_count + COUNT_W'(1);
            end
            if (r_plan.detach) begin
                n_has_owner[r_slot] = 1'b0;
            end
            if (r_plan.release_slot) begin
                n_in_use[r_slot]    = 1'b0;
                n_has_owner[r_slot] = 1'b0;
                n_count             = r_count - COUNT_W'(1);
            end
        end

        if (i_ctl.link) begin
            if (r_plan.link_new) begin
                if (r_plan.empty) begin
                    n_tail = r_slot;
                end else begin
                    older_we    = 1'b1;
                    older_waddr = r_slot;
                    older_wdata = r_head;
                    newer_we    = 1'b1;
                    newer_waddr = r_head;
                    newer_wdata = r_slot;
                end
                n_head = r_slot;
            end else if (r_plan.link_old) begin
                newer_we    = 1'b1;
                newer_waddr = r_slot;
                newer_wdata = r_tail;
                older_we    = 1'b1;
                older_waddr = r_tail;
                older_wdata = r_slot;
                n_tail      = r_slot;
            end
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (older_we) begin
            r_older_mem[older_waddr] <= older_wdata;
        end
        if (newer_we) begin
            r_newer_mem[newer_waddr] <= newer_wdata;
        end
        if (owner_we) begin
            r_owner_mem[r_slot] <= r_tile;
        end
        if (i_ctl.decode) begin
            r_rd_older <= r_older_mem[target];
            r_rd_newer <= r_newer_mem[target];
            r_rd_owner <= r_owner_mem[target];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_command;
            r_tile <= i_tile;
            r_sidx <= i_slot;
        end
        if (i_ctl.decode) begin
            r_slot    <= target;
            r_plan    <= plan;
            r_status  <= slot_cmd && !hit;
            r_granted <= is_alloc ? target : '0;
        end
        r_ev_valid <= n_ev_valid;
        r_ev_tile  <= n_ev_tile;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_in_use    <= '0;
            r_has_owner <= '0;
            r_grp_free  <= '1;
            for (int g = 0; g < NGRP; g++) begin
                r_grp_idx[g] <= '0;
            end
        end else begin
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_in_use    <= n_in_use;
            r_has_owner <= n_has_owner;
            r_grp_free  <= n_grp_free;
            for (int g = 0; g < NGRP; g++) begin
                r_grp_idx[g] <= n_grp_idx[g];
            end
        end
    end

    assign o_status        = r_status;
    assign o_granted_slot  = r_granted;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_tile  = r_ev_tile;
    assign o_used_slots    = r_count;

endmodule

// ----- src/lru_slot_pool_with_demote_core.sv -----
// ----------------------------------------------------------------------------
// lru_slot_pool_with_demote_core
// Pool of 64 backing slots kept in recency order for screen-cache tiles.
// ----------------------------------------------------------------------------
// A command item is taken at a rising edge with start high and busy low:
// allocate, touch, demote, detach, release or clear all, with its tile and
// slot fields. One result item follows for every command, on the o_ ports
// for a single cycle marked by o_result_valid; the receiver cannot stall
// it, and busy stays high until that cycle has passed.
// Clear, ignored and unknown commands go from decode straight to respond;
// detach, release, and allocate, touch or demote that find the slot
// already at its end of the list pass through update as well, and
// relinking the recency list (allocate, touch, demote) adds the link
// step before respond. The list memories take one pointer write per
// cycle each, which sets the unlink and link steps.
// The capacity register is written over its own valid/ready channel while
// no command is in flight. Reset empties the pool, sets capacity to 64
// and brings the block straight to idle.
// ----------------------------------------------------------------------------
module lru_slot_pool_with_demote_core
    import lspd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [TILE_W-1:0]  i_tile,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_data,
    output logic               o_result_valid,
    output logic               o_status,
    output logic [SLOT_W-1:0]  o_granted_slot,
    output logic               o_evicted_valid,
    output logic [TILE_W-1:0]  o_evicted_tile,
    output logic [COUNT_W-1:0] o_used_slots
);

    t_dp_ctl   ctl;
    t_dp_flags flags;
    logic      cfg_we;

    assign o_cfg_ready = ~busy;
    assign cfg_we      = i_cfg_valid & ~busy;

    lspd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_flags        (flags),
        .o_ctl          (ctl),
        .busy           (busy),
        .o_result_valid (o_result_valid)
    );

    lspd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_flags         (flags),
        .i_command       (i_command),
        .i_tile          (i_tile),
        .i_slot          (i_slot),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_status        (o_status),
        .o_granted_slot  (o_granted_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_tile  (o_evicted_tile),
        .o_used_slots    (o_used_slots)
    );

endmodule

// ----- src/lspd_checker.sv -----
// ----------------------------------------------------------------------------
// lspd_checker
// Port-level checks on the slot pool, bound to the top level.
// ----------------------------------------------------------------------------
module lspd_checker
    import lspd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_result_valid,
    input logic               o_status,
    input logic [SLOT_W-1:0]  o_granted_slot,
    input logic               o_evicted_valid,
    input logic [COUNT_W-1:0] o_used_slots
);

    // an accepted command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting an item");

    // the result strobe lasts one cycle and ends the command
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid && !busy)
        else $error("result strobe longer than one cycle");

    // an ignored command grants nothing and evicts nothing
    a_ignored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_status |-> o_granted_slot == '0 && !o_evicted_valid)
        else $error("ignored command reported a grant or eviction");

    // the use count moves only while a command is in flight
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && $past(!busy) |-> $stable(o_used_slots))
        else $error("use count changed while idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_used_slots <= COUNT_W'(SLOTS))
        else $error("use count beyond pool size");

endmodule

bind lru_slot_pool_with_demote_core lspd_checker u_lspd_checker (.*);
